[rtl/core/sts_pkg.sv]
`default_nettype none

package sts_pkg;

    // Field widths of the sprite words and the tile commands.
    localparam int WORD_W     = 16;
    localparam int ORG_W      = 9;
    localparam int CNT_W      = 3;
    localparam int ZOOM_W     = 4;
    localparam int SCALE_W    = 6;
    localparam int COLOUR_W   = 5;
    localparam int CODE_W     = 17;
    localparam int POS_W      = 10;
    localparam int PAL_W      = 9;
    localparam int PROD_W     = CNT_W + SCALE_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PALETTE_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DRAW_LAYER   = 1'b1;

    // Bit positions inside the sprite words.
    localparam int ORG_LSB     = 0;
    localparam int SIZE_LSB    = 9;
    localparam int ZOOM_LSB    = 12;
    localparam int FLIP_Y_BIT  = 15;
    localparam int FLIP_X_BIT  = 14;
    localparam int LAYER_BIT   = 13;
    localparam int COLOUR_LSB  = 8;
    localparam int MAP_MSB_BIT = 0;

    // Tile step at zoom zero.
    localparam logic [SCALE_W-1:0] SCALE_FULL = 6'd32;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    typedef struct packed {
        logic load;   // capture the sprite on the input bus
        logic step;   // emit the current tile into the output register
    } t_cmd;

    typedef struct packed {
        logic match;      // sprite on the input bus belongs to the drawn layer
        logic last_tile;  // current tile is the final one of the sprite
        logic out_free;   // output register can take a tile this cycle
    } t_status;

endpackage

`default_nettype wire

[rtl/core/sts_sprite_if.sv]
`default_nettype none

interface sts_sprite_if;
    logic                       valid;
    logic                       ready;
    logic [sts_pkg::WORD_W-1:0] y_word;
    logic [sts_pkg::WORD_W-1:0] x_word;
    logic [sts_pkg::WORD_W-1:0] attr_word;
    logic [sts_pkg::WORD_W-1:0] map_word;

    modport source (output valid, output y_word, output x_word, output attr_word,
                    output map_word, input ready);
    modport sink   (input valid, input y_word, input x_word, input attr_word,
                    input map_word, output ready);
endinterface

`default_nettype wire

[rtl/core/sts_tile_if.sv]
`default_nettype none

interface sts_tile_if;
    logic                        valid;
    logic                        ready;
    logic [sts_pkg::CODE_W-1:0]  tile_code;
    logic [sts_pkg::POS_W-1:0]   pos_x;
    logic [sts_pkg::POS_W-1:0]   pos_y;
    logic [sts_pkg::PAL_W-1:0]   palette;
    logic                        flip_x;
    logic                        flip_y;
    logic [sts_pkg::SCALE_W-1:0] scale_x;
    logic [sts_pkg::SCALE_W-1:0] scale_y;
    logic                        last;

    modport source (output valid, output tile_code, output pos_x, output pos_y,
                    output palette, output flip_x, output flip_y, output scale_x,
                    output scale_y, output last, input ready);
    modport sink   (input valid, input tile_code, input pos_x, input pos_y,
                    input palette, input flip_x, input flip_y, input scale_x,
                    input scale_y, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/sts_ctrl.sv]
`default_nettype none

module sts_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  sts_pkg::t_status i_status,
    output sts_pkg::t_cmd    o_cmd
);

    sts_pkg::t_state r_state;
    sts_pkg::t_state n_state;

    always_comb begin
        o_in_ready   = (r_state == sts_pkg::S_IDLE);
        o_cmd.load   = i_in_valid && (r_state == sts_pkg::S_IDLE);
        o_cmd.step   = (r_state == sts_pkg::S_RUN) && i_status.out_free;
        n_state      = r_state;
        unique case (r_state)
            sts_pkg::S_IDLE: begin
                if (o_cmd.load && i_status.match) begin
                    n_state = sts_pkg::S_RUN;
                end
            end
            sts_pkg::S_RUN: begin
                if (o_cmd.step && i_status.last_tile) begin
                    n_state = sts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A skipped sprite never starts a tile walk.
    a_skip_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load && !i_status.match |=> r_state == sts_pkg::S_IDLE)
        else $error("skipped sprite left the idle state");

    // A walk only ends on the final tile.
    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sts_pkg::S_RUN) && !(o_cmd.step && i_status.last_tile)
        |=> r_state == sts_pkg::S_RUN)
        else $error("tile walk ended early");

endmodule

`default_nettype wire

[rtl/core/sts_dp.sv]
`default_nettype none

module sts_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire  [sts_pkg::WORD_W-1:0]        i_y_word,
    input  wire  [sts_pkg::WORD_W-1:0]        i_x_word,
    input  wire  [sts_pkg::WORD_W-1:0]        i_attr_word,
    input  wire  [sts_pkg::WORD_W-1:0]        i_map_word,
    input  wire                               i_cfg_we,
    input  wire  [sts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [sts_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  sts_pkg::t_cmd                     i_cmd,
    output sts_pkg::t_status                  o_status,
    sts_tile_if.source                        o_tile
);

    // Configuration.
    logic [sts_pkg::CFG_DATA_W-1:0] r_palette_base;
    logic                           r_draw_layer;

    // Captured sprite.
    logic [sts_pkg::ORG_W-1:0]   r_ox, r_oy;
    logic [sts_pkg::CNT_W-1:0]   r_cols_m1, r_rows_m1;
    logic [sts_pkg::SCALE_W-1:0] r_sx, r_sy;
    logic                        r_fx, r_fy;
    logic [sts_pkg::PAL_W-1:0]   r_pal;

    // Walk counters.
    logic [sts_pkg::CODE_W-1:0]  r_code;
    logic [sts_pkg::CNT_W-1:0]   r_row, r_col;

    // Output register.
    logic                        r_out_valid;
    logic [sts_pkg::CODE_W-1:0]  r_out_code;
    logic [sts_pkg::POS_W-1:0]   r_out_x, r_out_y;
    logic [sts_pkg::PAL_W-1:0]   r_out_pal;
    logic                        r_out_fx, r_out_fy;
    logic [sts_pkg::SCALE_W-1:0] r_out_sx, r_out_sy;
    logic                        r_out_last;

    logic [sts_pkg::CNT_W-1:0]   w_cx, w_ry;
    logic [sts_pkg::PROD_W-1:0]  w_prod_x, w_prod_y;
    logic [sts_pkg::POS_W-1:0]   w_pos_x, w_pos_y;
    logic [sts_pkg::ZOOM_W-1:0]  w_zoom_x, w_zoom_y;
    logic [sts_pkg::COLOUR_W-1:0] w_colour;

    always_comb begin
        w_zoom_x = i_x_word[sts_pkg::ZOOM_LSB +: sts_pkg::ZOOM_W];
        w_zoom_y = i_y_word[sts_pkg::ZOOM_LSB +: sts_pkg::ZOOM_W];
        w_colour = i_attr_word[sts_pkg::COLOUR_LSB +: sts_pkg::COLOUR_W];

        w_cx     = r_fx ? (r_cols_m1 - r_col) : r_col;
        w_ry     = r_fy ? (r_rows_m1 - r_row) : r_row;
        w_prod_x = sts_pkg::PROD_W'(w_cx) * sts_pkg::PROD_W'(r_sx);
        w_prod_y = sts_pkg::PROD_W'(w_ry) * sts_pkg::PROD_W'(r_sy);
        w_pos_x  = sts_pkg::POS_W'(r_ox) + sts_pkg::POS_W'(w_prod_x >> 1);
        w_pos_y  = sts_pkg::POS_W'(r_oy) + sts_pkg::POS_W'(w_prod_y >> 1);

        o_status.match     = (i_attr_word[sts_pkg::LAYER_BIT] == r_draw_layer);
        o_status.last_tile = (r_row == r_rows_m1) && (r_col == r_cols_m1);
        o_status.out_free  = !r_out_valid || o_tile.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_base <= '0;
            r_draw_layer   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sts_pkg::CFG_IDX_PALETTE_BASE: r_palette_base <= i_cfg_wdata;
                sts_pkg::CFG_IDX_DRAW_LAYER:   r_draw_layer   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_oy      <= i_y_word[sts_pkg::ORG_LSB +: sts_pkg::ORG_W];
            r_ox      <= i_x_word[sts_pkg::ORG_LSB +: sts_pkg::ORG_W];
            r_rows_m1 <= i_y_word[sts_pkg::SIZE_LSB +: sts_pkg::CNT_W];
            r_cols_m1 <= i_x_word[sts_pkg::SIZE_LSB +: sts_pkg::CNT_W];
            r_sy      <= sts_pkg::SCALE_FULL - sts_pkg::SCALE_W'(w_zoom_y);
            r_sx      <= sts_pkg::SCALE_FULL - sts_pkg::SCALE_W'(w_zoom_x);
            r_fy      <= i_attr_word[sts_pkg::FLIP_Y_BIT];
            r_fx      <= i_attr_word[sts_pkg::FLIP_X_BIT];
            r_pal     <= sts_pkg::PAL_W'(w_colour) + sts_pkg::PAL_W'(r_palette_base);
            r_code    <= {i_attr_word[sts_pkg::MAP_MSB_BIT], i_map_word};
            r_row     <= '0;
            r_col     <= '0;
        end else if (i_cmd.step) begin
            r_code <= r_code + sts_pkg::CODE_W'(1);
            if (r_col == r_cols_m1) begin
                r_col <= '0;
                r_row <= r_row + sts_pkg::CNT_W'(1);
            end else begin
                r_col <= r_col + sts_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_code <= r_code;
            r_out_x    <= w_pos_x;
            r_out_y    <= w_pos_y;
            r_out_pal  <= r_pal;
            r_out_fx   <= r_fx;
            r_out_fy   <= r_fy;
            r_out_sx   <= r_sx;
            r_out_sy   <= r_sy;
            r_out_last <= o_status.last_tile;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (o_tile.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_tile.valid     = r_out_valid;
    assign o_tile.tile_code = r_out_code;
    assign o_tile.pos_x     = r_out_x;
    assign o_tile.pos_y     = r_out_y;
    assign o_tile.palette   = r_out_pal;
    assign o_tile.flip_x    = r_out_fx;
    assign o_tile.flip_y    = r_out_fy;
    assign o_tile.scale_x   = r_out_sx;
    assign o_tile.scale_y   = r_out_sy;
    assign o_tile.last      = r_out_last;

    // The final tile of a walk shows up flagged in the output register.
    a_last_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && o_status.last_tile |=> r_out_valid && r_out_last)
        else $error("final tile not flagged");

    // The walk counters never run past the sprite size.
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_row <= r_rows_m1) && (r_col <= r_cols_m1))
        else $error("tile walk out of range");

endmodule

`default_nettype wire

[rtl/core/sprite_tile_sequencer_top.sv]
`default_nettype none

// Sprite tile sequencer. Each item on i_sprite is one sprite given as its four
// attribute words. If the sprite's layer bit (bit 13 of attr_word) differs from
// the draw_layer register, the sprite is taken and yields nothing. Otherwise the
// block emits one tile command per tile on o_tile, rows outer and columns inner,
// each axis walked backwards when its flip bit is set, with the final command of
// the sprite marked by last. A sprite of W by H tiles, W and H each from 1 to 8,
// is taken in and then yields W*H commands, one tile per cycle while o_tile
// keeps ready high; the 3-bit size fields and tile walk counters in the datapath
// set those bounds. The next sprite is taken the cycle after the final tile has
// entered the output register, even while that tile still waits to be taken.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_wdata: index 0 is
// palette_base, index 1 is draw_layer (bit 0 of the data). Both reset to zero
// and should be written only while no sprite is in progress.

module sprite_tile_sequencer_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    sts_sprite_if.sink                     i_sprite,
    sts_tile_if.source                     o_tile,
    input  wire                            i_cfg_we,
    input  wire [sts_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [sts_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    sts_pkg::t_cmd    w_cmd;
    sts_pkg::t_status w_status;
    logic             w_in_ready;

    // The controller decides when a sprite is taken and when each tile is
    // pushed into the output register; it stays idle for skipped sprites.
    sts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sprite.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    assign i_sprite.ready = w_in_ready;

    // The datapath unpacks the sprite, walks the tile grid, forms each
    // command and holds the output register that drives o_tile.
    sts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_y_word    (i_sprite.y_word),
        .i_x_word    (i_sprite.x_word),
        .i_attr_word (i_sprite.attr_word),
        .i_map_word  (i_sprite.map_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_tile      (o_tile)
    );

endmodule

`default_nettype wire
